// ----- rtl/core/cnht_pkg.sv -----
package cnht_pkg;

   localparam int NODE_COUNT = 21;
   localparam int MASK_W = 21;
   localparam int ID_W = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 160;

   localparam logic [15:0] HEARTBEAT_LIMIT_RESET = 16'd800;
   localparam logic [15:0] HEARTBEAT_MAX = 16'hffff;
   localparam logic [7:0] COUNT_SAT = 8'hee;

   localparam logic [3:0] LO_APPLY = 4'h1;
   localparam logic [3:0] LO_STOP = 4'h2;
   localparam logic [3:0] LO_CLEAR = 4'h3;
   localparam logic [3:0] HI_REPORT = 4'h1;
   localparam logic [3:0] HI_ACK = 4'h2;

   localparam logic [3:0] HEAD_ADDR_CLR = 4'h3;
   localparam logic [3:0] HEAD_ADDR_SET = 4'h2;
   localparam logic [3:0] HEAD_RES_CLR = 4'hc;
   localparam logic [3:0] HEAD_RES_SET = 4'h8;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_LIMIT = 1'd1;

   typedef enum logic [1:0] {
      ACT_FRAME = 2'd0,
      ACT_EVAL  = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_HOST  = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EVAL = 1'b1
   } state_type;

   typedef struct packed {
      logic [7:0]  error;
      logic [7:0]  apply_cnt;
      logic [7:0]  stop_cnt;
      logic [7:0]  report_cnt;
      logic [15:0] result;
      logic [15:0] pocket;
   } node_entry_type;

   typedef struct packed {
      logic move_set;
      logic apply_set;
      logic apply_clr;
      logic recv_set;
      logic recv_clr;
      logic report_set;
      logic report_clr;
      logic pending_clr;
      logic addr_stop;
      logic result_stop;
   } eval_effect_type;

   function automatic logic [7:0] bump(input logic [7:0] count);
      bump = (count >= COUNT_SAT) ? COUNT_SAT : count + 8'd1;
   endfunction

endpackage

// ----- rtl/core/cnht_eval.sv -----
module cnht_eval (
   input  cnht_pkg::node_entry_type  entry_cur,
   input  logic [5:0][7:0]           held_bytes,
   input  logic                      auto_mode,
   output cnht_pkg::node_entry_type  entry_new,
   output cnht_pkg::eval_effect_type effect
);

   logic [3:0] lo_nibble;
   logic [3:0] hi_nibble;
   logic [7:0] apply_cnt;
   logic [7:0] stop_cnt;
   logic [7:0] report_cnt;

   assign lo_nibble = held_bytes[0][3:0];
   assign hi_nibble = held_bytes[0][7:4];
   assign apply_cnt = cnht_pkg::bump(entry_cur.apply_cnt);
   assign stop_cnt = cnht_pkg::bump(entry_cur.stop_cnt);
   assign report_cnt = cnht_pkg::bump(entry_cur.report_cnt);

   always_comb begin
      entry_new = entry_cur;
      effect = '0;
      entry_new.error = held_bytes[3];

      if (!auto_mode) begin
         case (lo_nibble)
            cnht_pkg::LO_APPLY: begin
               entry_new.apply_cnt = apply_cnt;
               entry_new.stop_cnt = '0;
               if (apply_cnt == 8'd1) begin
                  effect.move_set = 1'b1;
                  effect.apply_set = 1'b1;
               end
            end
            cnht_pkg::LO_STOP: begin
               entry_new.stop_cnt = stop_cnt;
               entry_new.apply_cnt = '0;
               effect.pending_clr = 1'b1;
               if (stop_cnt == 8'd1) begin
                  effect.addr_stop = 1'b1;
                  effect.apply_clr = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else begin
         case (lo_nibble)
            cnht_pkg::LO_STOP: begin
               entry_new.stop_cnt = stop_cnt;
               effect.pending_clr = 1'b1;
               if (stop_cnt == 8'd1) begin
                  effect.addr_stop = 1'b1;
                  effect.recv_set = 1'b1;
               end
            end
            cnht_pkg::LO_CLEAR: begin
               entry_new.stop_cnt = '0;
               effect.recv_clr = 1'b1;
            end
            default: begin
            end
         endcase
      end

      case (hi_nibble)
         cnht_pkg::HI_REPORT: begin
            entry_new.report_cnt = report_cnt;
            if (report_cnt == 8'd1) begin
               entry_new.result = {held_bytes[1], held_bytes[2]};
               entry_new.pocket = {held_bytes[4], held_bytes[5]};
               effect.report_set = 1'b1;
            end
         end
         cnht_pkg::HI_ACK: begin
            entry_new.report_cnt = '0;
            effect.result_stop = 1'b1;
            effect.report_clr = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/can_node_handshake_tracker_core.sv -----
// Tracks address and result handshakes with up to NODE_COUNT CAN nodes. A frame, tick or host
// item, or an evaluate item naming no node, has its result registered at transfer; an evaluate
// item naming a node has the node's entry read from the per-node memory at transfer, then
// modified and written back with its result registered in ST_EVAL. One item is in work at a
// time, and a new item is taken as soon as the result register is free or being emptied.
// Per-node entries carry a valid bit cleared by reset, so no clearing pass follows reset.
module can_node_handshake_tracker_core #(
   parameter int NODE_COUNT = cnht_pkg::NODE_COUNT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // frame_id, data_b0, data_b1, data_b2, data_b3, data_b4, data_b5, host_mask
   input  logic [cnht_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action, is_standard
   input  logic [cnht_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // live_mask, apply_mask, recv_addr_mask, result_mask, pending_addr_mask, head_flags,
   // move_one, node_number, node_error, node_result, node_pocket, zero fill
   output logic [cnht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cnht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cnht_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   cnht_pkg::state_type       state_ff, state_in;
   cnht_pkg::action_type      action;
   cnht_pkg::node_entry_type  mem [NODE_COUNT];
   cnht_pkg::node_entry_type  rd_entry_ff;
   cnht_pkg::node_entry_type  entry_cur;
   cnht_pkg::node_entry_type  entry_new;
   cnht_pkg::eval_effect_type effect;

   logic                    rd_valid_ff;
   logic [NODE_COUNT-1:0]   valid_ff;
   logic                    auto_ff, auto_in;
   logic [15:0]             limit_ff, limit_in;
   logic [cnht_pkg::ID_W-1:0] held_id_ff, held_id_in;
   logic [5:0][7:0]         held_bytes_ff, held_bytes_in;
   logic                    frame_held_ff, frame_held_in;
   logic [NODE_COUNT-1:0]   live_ff, live_in;
   logic [NODE_COUNT-1:0]   apply_ff, apply_in;
   logic [NODE_COUNT-1:0]   recv_ff, recv_in;
   logic [NODE_COUNT-1:0]   report_ff, report_in;
   logic [NODE_COUNT-1:0]   pending_ff, pending_in;
   logic [3:0]              head_ff, head_in;
   logic                    move_ff, move_in;
   logic [15:0]             heartbeat_ff, heartbeat_in;
   logic [15:0]             heartbeat_next;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [cnht_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    in_eval;
   logic                    node_ok;
   logic                    rsp_load;
   logic [IDX_W-1:0]        idx;
   logic [NODE_COUNT-1:0]   node_bit;
   logic [NODE_COUNT-1:0]   host_bits;
   logic [5:0][7:0]         req_bytes;
   logic [31:0]             live_w, apply_w, recv_w, report_w, pending_w;
   logic [4:0]              node_number;
   logic [7:0]              node_error;
   logic [15:0]             node_result;
   logic [15:0]             node_pocket;

   assign action = cnht_pkg::action_type'(req_tuser[1:0]);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid && csr_ready;

   assign req_bytes[0] = req_tdata[18:11];
   assign req_bytes[1] = req_tdata[26:19];
   assign req_bytes[2] = req_tdata[34:27];
   assign req_bytes[3] = req_tdata[42:35];
   assign req_bytes[4] = req_tdata[50:43];
   assign req_bytes[5] = req_tdata[58:51];
   assign host_bits = NODE_COUNT'(32'(req_tdata[79:59]));

   assign node_ok = frame_held_ff && (held_id_ff != '0)
                    && (held_id_ff <= cnht_pkg::ID_W'(NODE_COUNT));
   assign idx = IDX_W'(held_id_ff - cnht_pkg::ID_W'(1));
   assign node_bit = NODE_COUNT'(1) << idx;
   assign entry_cur = rd_valid_ff ? rd_entry_ff : '0;
   assign heartbeat_next = (heartbeat_ff == cnht_pkg::HEARTBEAT_MAX) ? heartbeat_ff
                           : heartbeat_ff + 16'd1;

   cnht_eval u_eval (
      .entry_cur  (entry_cur),
      .held_bytes (held_bytes_ff),
      .auto_mode  (auto_ff),
      .entry_new  (entry_new),
      .effect     (effect)
   );

   always_comb begin
      case (state_ff)
         cnht_pkg::ST_IDLE: begin
            if (req_fire && (action == cnht_pkg::ACT_EVAL) && node_ok) begin
               state_in = cnht_pkg::ST_EVAL;
            end else begin
               state_in = cnht_pkg::ST_IDLE;
            end
         end
         cnht_pkg::ST_EVAL: begin
            state_in = cnht_pkg::ST_IDLE;
         end
         default: begin
            state_in = cnht_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         cnht_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            in_eval = 1'b0;
         end
         cnht_pkg::ST_EVAL: begin
            req_tready = 1'b0;
            in_eval = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
            in_eval = 1'b0;
         end
      endcase
   end

   always_comb begin
      auto_in = auto_ff;
      limit_in = limit_ff;
      if (csr_fire) begin
         case (csr_index)
            cnht_pkg::CSR_AUTO_MODE: auto_in = csr_data[0];
            cnht_pkg::CSR_HEARTBEAT_LIMIT: limit_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      held_id_in = held_id_ff;
      held_bytes_in = held_bytes_ff;
      frame_held_in = frame_held_ff;
      live_in = live_ff;
      apply_in = apply_ff;
      recv_in = recv_ff;
      report_in = report_ff;
      pending_in = pending_ff;
      head_in = head_ff;
      move_in = move_ff;
      heartbeat_in = heartbeat_ff;
      node_number = '0;
      node_error = '0;
      node_result = '0;
      node_pocket = '0;

      if (req_fire) begin
         case (action)
            cnht_pkg::ACT_FRAME: begin
               held_id_in = req_tdata[10:0];
               frame_held_in = 1'b1;
               if (req_tuser[2]) begin
                  held_bytes_in = req_bytes;
               end
            end
            cnht_pkg::ACT_TICK: begin
               heartbeat_in = heartbeat_next;
               if (heartbeat_next >= limit_ff) begin
                  live_in = '0;
               end
            end
            cnht_pkg::ACT_HOST: begin
               pending_in = pending_ff | host_bits;
            end
            default: begin
            end
         endcase
      end

      if (in_eval) begin
         live_in = live_ff | node_bit;
         heartbeat_in = '0;
         if (effect.move_set) begin
            move_in = 1'b1;
         end
         if (effect.apply_set) begin
            apply_in = apply_ff | node_bit;
         end
         if (effect.apply_clr) begin
            apply_in = apply_ff & ~node_bit;
         end
         if (effect.recv_set) begin
            recv_in = recv_ff | node_bit;
         end
         if (effect.recv_clr) begin
            recv_in = recv_ff & ~node_bit;
         end
         if (effect.report_set) begin
            report_in = report_ff | node_bit;
         end
         if (effect.report_clr) begin
            report_in = report_ff & ~node_bit;
         end
         if (effect.pending_clr) begin
            pending_in = pending_ff & ~node_bit;
         end
         if (effect.addr_stop) begin
            head_in = (head_in & ~cnht_pkg::HEAD_ADDR_CLR) | cnht_pkg::HEAD_ADDR_SET;
         end
         if (effect.result_stop) begin
            head_in = (head_in & ~cnht_pkg::HEAD_RES_CLR) | cnht_pkg::HEAD_RES_SET;
         end
         node_number = held_id_ff[4:0];
         node_error = entry_new.error;
         node_result = entry_new.result;
         node_pocket = entry_new.pocket;
      end

      rsp_load = in_eval || (req_fire && !((action == cnht_pkg::ACT_EVAL) && node_ok));
      live_w = 32'(live_in);
      apply_w = 32'(apply_in);
      recv_w = 32'(recv_in);
      report_w = 32'(report_in);
      pending_w = 32'(pending_in);
      rsp_data_in = {5'd0, node_pocket, node_result, node_error, node_number, move_in, head_in,
                     pending_w[20:0], report_w[20:0], recv_w[20:0], apply_w[20:0],
                     live_w[20:0]};

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cnht_pkg::ST_IDLE;
         auto_ff <= 1'b1;
         limit_ff <= cnht_pkg::HEARTBEAT_LIMIT_RESET;
         held_id_ff <= '0;
         held_bytes_ff <= '0;
         frame_held_ff <= 1'b0;
         live_ff <= '0;
         apply_ff <= '0;
         recv_ff <= '0;
         report_ff <= '0;
         pending_ff <= '0;
         head_ff <= '0;
         move_ff <= 1'b0;
         heartbeat_ff <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         auto_ff <= auto_in;
         limit_ff <= limit_in;
         held_id_ff <= held_id_in;
         held_bytes_ff <= held_bytes_in;
         frame_held_ff <= frame_held_in;
         live_ff <= live_in;
         apply_ff <= apply_in;
         recv_ff <= recv_in;
         report_ff <= report_in;
         pending_ff <= pending_in;
         head_ff <= head_in;
         move_ff <= move_in;
         heartbeat_ff <= heartbeat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_eval) begin
            valid_ff[idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (req_fire && (action == cnht_pkg::ACT_EVAL) && node_ok) begin
         rd_entry_ff <= mem[idx];
         rd_valid_ff <= valid_ff[idx];
      end
      if (in_eval) begin
         mem[idx] <= entry_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ----- rtl/core/cnht_checker.sv -----
module cnht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [cnht_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [cnht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   else $error("stalled result changed");

   // No transfer is taken on the request side while a result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(req_tvalid && req_tready))
   else $error("request taken while result stalled");

   // Items other than evaluate give their result in the next cycle with no node.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[1:0] != cnht_pkg::ACT_EVAL)
      |=> rsp_tvalid && (rsp_tdata[114:110] == 5'd0))
   else $error("missing or wrong result for non-evaluate item");

   // Host-owned head flags are never set by the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[105] && !rsp_tdata[107])
   else $error("host head flag set");

   // An evaluated node is marked live in the same result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[114:110] != 5'd0) && (rsp_tdata[114:110] <= 5'd21)
      |-> |(rsp_tdata[20:0] & (21'd1 << (rsp_tdata[114:110] - 5'd1))))
   else $error("evaluated node not live");

endmodule

bind can_node_handshake_tracker_core cnht_checker u_cnht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/can_node_handshake_tracker_core_tb.sv -----
`timescale 1ns / 1ps

module can_node_handshake_tracker_core_tb;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [20:0] host_mask;
      logic [7:0]  b5;
      logic [7:0]  b4;
      logic [7:0]  b3;
      logic [7:0]  b2;
      logic [7:0]  b1;
      logic [7:0]  b0;
      logic [10:0] frame_id;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  fill;
      logic [15:0] pocket;
      logic [15:0] result;
      logic [7:0]  error;
      logic [4:0]  node;
      logic        move;
      logic [3:0]  head;
      logic [20:0] pending;
      logic [20:0] report;
      logic [20:0] recv;
      logic [20:0] apply;
      logic [20:0] live;
   } status_word_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [cnht_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [cnht_pkg::REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cnht_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [cnht_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cnht_pkg::CSR_DATA_W-1:0] csr_data;

   // Tracker state as the block should hold it.
   logic        auto_on = 1'b1;
   logic [15:0] beat_limit = cnht_pkg::HEARTBEAT_LIMIT_RESET;
   logic [10:0] held_id = '0;
   logic [7:0]  held_bytes [6] = '{default: 8'h00};
   logic        frame_held = 1'b0;
   logic [7:0]  err_tab [cnht_pkg::NODE_COUNT] = '{default: 8'h00};
   logic [7:0]  apply_edges [cnht_pkg::NODE_COUNT] = '{default: 8'h00};
   logic [7:0]  stop_edges [cnht_pkg::NODE_COUNT] = '{default: 8'h00};
   logic [7:0]  report_edges [cnht_pkg::NODE_COUNT] = '{default: 8'h00};
   logic [15:0] result_tab [cnht_pkg::NODE_COUNT] = '{default: 16'h0000};
   logic [15:0] pocket_tab [cnht_pkg::NODE_COUNT] = '{default: 16'h0000};
   logic [20:0] live_bits = '0;
   logic [20:0] apply_bits = '0;
   logic [20:0] recv_bits = '0;
   logic [20:0] report_bits = '0;
   logic [20:0] pending_bits = '0;
   logic [3:0]  head_bits = '0;
   logic        move_flag = 1'b0;
   logic [15:0] heartbeat = '0;

   status_word_type status_expect [$];
   int errors = 0;
   int items_sent = 0;
   int send_idle_pct = 12;
   int recv_idle_pct = 80;
   int hold_left = 0;
   int stall_cycles = 0;

   can_node_handshake_tracker_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [7:0] edge_step(input logic [7:0] c);
      return (c >= cnht_pkg::COUNT_SAT) ? cnht_pkg::COUNT_SAT : c + 8'd1;
   endfunction

   function automatic status_word_type track_item(input cnht_pkg::action_type act,
                                                  input logic is_std, input req_word_type f);
      status_word_type s;
      int k;
      logic [20:0] node_bit;
      logic [4:0] node;
      node = '0;
      k = 0;
      case (act)
         cnht_pkg::ACT_FRAME: begin
            held_id = f.frame_id;
            if (is_std) begin
               held_bytes[0] = f.b0;
               held_bytes[1] = f.b1;
               held_bytes[2] = f.b2;
               held_bytes[3] = f.b3;
               held_bytes[4] = f.b4;
               held_bytes[5] = f.b5;
            end
            frame_held = 1'b1;
         end
         cnht_pkg::ACT_EVAL: begin
            if (frame_held && held_id != 0 && held_id <= cnht_pkg::NODE_COUNT) begin
               node = held_id[4:0];
               k = held_id - 1;
               node_bit = 21'd1 << k;
               err_tab[k] = held_bytes[3];
               live_bits |= node_bit;
               heartbeat = '0;
               if (!auto_on) begin
                  if (held_bytes[0][3:0] == cnht_pkg::LO_APPLY) begin
                     apply_edges[k] = edge_step(apply_edges[k]);
                     if (apply_edges[k] == 8'd1) begin
                        move_flag = 1'b1;
                        apply_bits |= node_bit;
                     end
                     stop_edges[k] = '0;
                  end else if (held_bytes[0][3:0] == cnht_pkg::LO_STOP) begin
                     stop_edges[k] = edge_step(stop_edges[k]);
                     pending_bits &= ~node_bit;
                     if (stop_edges[k] == 8'd1) begin
                        head_bits = (head_bits & ~cnht_pkg::HEAD_ADDR_CLR)
                                    | cnht_pkg::HEAD_ADDR_SET;
                        apply_bits &= ~node_bit;
                     end
                     apply_edges[k] = '0;
                  end
               end else begin
                  if (held_bytes[0][3:0] == cnht_pkg::LO_STOP) begin
                     stop_edges[k] = edge_step(stop_edges[k]);
                     pending_bits &= ~node_bit;
                     if (stop_edges[k] == 8'd1) begin
                        head_bits = (head_bits & ~cnht_pkg::HEAD_ADDR_CLR)
                                    | cnht_pkg::HEAD_ADDR_SET;
                        recv_bits |= node_bit;
                     end
                  end else if (held_bytes[0][3:0] == cnht_pkg::LO_CLEAR) begin
                     stop_edges[k] = '0;
                     recv_bits &= ~node_bit;
                  end
               end
               if (held_bytes[0][7:4] == cnht_pkg::HI_REPORT) begin
                  report_edges[k] = edge_step(report_edges[k]);
                  if (report_edges[k] == 8'd1) begin
                     result_tab[k] = {held_bytes[1], held_bytes[2]};
                     pocket_tab[k] = {held_bytes[4], held_bytes[5]};
                     report_bits |= node_bit;
                  end
               end else if (held_bytes[0][7:4] == cnht_pkg::HI_ACK) begin
                  head_bits = (head_bits & ~cnht_pkg::HEAD_RES_CLR) | cnht_pkg::HEAD_RES_SET;
                  report_bits &= ~node_bit;
                  report_edges[k] = '0;
               end
            end
         end
         cnht_pkg::ACT_TICK: begin
            if (heartbeat != cnht_pkg::HEARTBEAT_MAX) heartbeat++;
            if (heartbeat >= beat_limit) live_bits = '0;
         end
         default: begin
            pending_bits |= f.host_mask;
         end
      endcase
      s = '0;
      s.live = live_bits;
      s.apply = apply_bits;
      s.recv = recv_bits;
      s.report = report_bits;
      s.pending = pending_bits;
      s.head = head_bits;
      s.move = move_flag;
      s.node = node;
      if (node != 0) begin
         s.error = err_tab[k];
         s.result = result_tab[k];
         s.pocket = pocket_tab[k];
      end
      return s;
   endfunction

   task automatic send_item(input cnht_pkg::action_type act, input logic is_std,
                            input req_word_type f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= f;
      req_tuser <= {is_std, act};
      do @(posedge clock); while (!req_tready);
      status_expect.push_back(track_item(act, is_std, f));
      items_sent++;
   endtask

   task automatic write_csr(input logic [cnht_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == cnht_pkg::CSR_AUTO_MODE) auto_on = value[0];
      else beat_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_expect.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic frame_and_eval(input logic [10:0] id, input logic is_std,
                                 input logic [7:0] cmd, input logic [39:0] payload);
      req_word_type f;
      f = '0;
      f.frame_id = id;
      f.b0 = cmd;
      {f.b1, f.b2, f.b3, f.b4, f.b5} = payload;
      send_item(cnht_pkg::ACT_FRAME, is_std, f);
      send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
   endtask

   function automatic logic [7:0] pick_command();
      logic [3:0] lo;
      logic [3:0] hi;
      case ($urandom_range(4))
         0: lo = 4'h0;
         1: lo = cnht_pkg::LO_APPLY;
         2: lo = cnht_pkg::LO_STOP;
         3: lo = cnht_pkg::LO_CLEAR;
         default: lo = 4'($urandom_range(15));
      endcase
      case ($urandom_range(3))
         0: hi = 4'h0;
         1: hi = cnht_pkg::HI_REPORT;
         2: hi = cnht_pkg::HI_ACK;
         default: hi = 4'($urandom_range(15));
      endcase
      return {hi, lo};
   endfunction

   task automatic send_random_item();
      logic [95:0] bits;
      req_word_type f;
      int pick;
      bits = {$urandom, $urandom, $urandom};
      f = bits[79:0];
      pick = $urandom_range(99);
      if (pick < 45) begin
         f.frame_id = 11'($urandom_range(1, cnht_pkg::NODE_COUNT));
         f.b0 = pick_command();
         send_item(cnht_pkg::ACT_FRAME, 1'b1, f);
         send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
         if ($urandom_range(4) == 0) send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
      end else if (pick < 60) begin
         send_item(cnht_pkg::ACT_TICK, 1'($urandom_range(1)), f);
      end else if (pick < 70) begin
         if ($urandom_range(1)) begin
            f.host_mask = 21'd1 << $urandom_range(cnht_pkg::NODE_COUNT - 1);
         end
         send_item(cnht_pkg::ACT_HOST, 1'($urandom_range(1)), f);
      end else if (pick < 85) begin
         if ($urandom_range(1)) f.frame_id = 11'($urandom_range(1, cnht_pkg::NODE_COUNT));
         send_item(cnht_pkg::ACT_FRAME, 1'($urandom_range(1)), f);
         send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
      end else begin
         send_item(cnht_pkg::action_type'($urandom_range(3)), 1'($urandom_range(1)), f);
      end
   endtask

   task automatic test_directed();
      req_word_type f;
      f = '0;
      send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
      send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      send_item(cnht_pkg::ACT_HOST, 1'b1, '1);
      frame_and_eval(11'd0, 1'b1, 8'h12, 40'h01_02_03_04_05);
      frame_and_eval(11'h7ff, 1'b1, 8'hff, '1);
      frame_and_eval(11'd1, 1'b1, 8'h12, '1);
      send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
      frame_and_eval(11'd21, 1'b1, 8'h23, 40'h80_00_80_00_80);
      frame_and_eval(11'd21, 1'b0, 8'h12, 40'h5a_5a_5a_5a_5a);
      frame_and_eval(11'd3, 1'b1, 8'hff, 40'h11_22_33_44_55);
      settle_idle();
      write_csr(cnht_pkg::CSR_AUTO_MODE, 16'd0);
      frame_and_eval(11'd2, 1'b1, 8'h01, 40'h12_34_56_78_9a);
      send_item(cnht_pkg::ACT_EVAL, 1'b0, f);
      frame_and_eval(11'd2, 1'b1, 8'h02, 40'h00_00_00_00_00);
      frame_and_eval(11'd2, 1'b1, 8'h21, 40'hff_00_ff_00_ff);
      settle_idle();
   endtask

   task automatic test_heartbeat();
      req_word_type f;
      f = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'd0);
      frame_and_eval(11'd4, 1'b1, 8'h00, '0);
      send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      settle_idle();
      write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'd1);
      frame_and_eval(11'd5, 1'b1, 8'h00, '0);
      send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      settle_idle();
      write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'd3);
      frame_and_eval(11'd6, 1'b1, 8'h00, '0);
      repeat (4) send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      settle_idle();
      // Ticks at the widest limit leave the live mask alone.
      write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'hffff);
      frame_and_eval(11'd7, 1'b1, 8'h00, '0);
      repeat (8) send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      frame_and_eval(11'd8, 1'b1, 8'h00, '0);
      send_item(cnht_pkg::ACT_TICK, 1'b0, f);
      settle_idle();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 64;
      repeat (30) send_random_item();
      settle_idle();
   endtask

   task automatic test_random(input int s_pct, input int r_pct, input int count);
      int stop_at;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      write_csr(cnht_pkg::CSR_AUTO_MODE, 16'($urandom_range(1)));
      case ($urandom_range(3))
         0: write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, cnht_pkg::HEARTBEAT_LIMIT_RESET);
         1: write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'hffff);
         default: write_csr(cnht_pkg::CSR_HEARTBEAT_LIMIT, 16'($urandom_range(1, 12)));
      endcase
      stop_at = items_sent + count;
      while (items_sent < stop_at) send_random_item();
      settle_idle();
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      status_word_type got;
      status_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (status_expect.size() == 0) begin
            $display("%0t: unexpected result transfer expected none actual %h", $time, got);
            errors++;
         end else begin
            want = status_expect.pop_front();
            compare_field("live_mask", 32'(want.live), 32'(got.live));
            compare_field("apply_mask", 32'(want.apply), 32'(got.apply));
            compare_field("recv_addr_mask", 32'(want.recv), 32'(got.recv));
            compare_field("result_mask", 32'(want.report), 32'(got.report));
            compare_field("pending_addr_mask", 32'(want.pending), 32'(got.pending));
            compare_field("head_flags", 32'(want.head), 32'(got.head));
            compare_field("move_one", 32'(want.move), 32'(got.move));
            compare_field("node_number", 32'(want.node), 32'(got.node));
            compare_field("node_error", 32'(want.error), 32'(got.error));
            compare_field("node_result", 32'(want.result), 32'(got.result));
            compare_field("node_pocket", 32'(want.pocket), 32'(got.pocket));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_heartbeat();
      test_backpressure();
      test_random(12, 80, 140);
      test_random(80, 12, 140);
      test_random(0, 0, 140);
      settle_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
